FILE: rtl/core/ucer_pkg.sv
// Shared types, codes and descriptor tables for the USB control endpoint responder.
// No dependencies; every other file of the block but ucer_stream_if imports this package.
package ucer_pkg;

    localparam int PACKET_BYTES = 8;

    // Control phase codes.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_DEV0     = 4'd1;
    localparam logic [3:0] PH_DEV1     = 4'd2;
    localparam logic [3:0] PH_DEV2     = 4'd3;
    localparam logic [3:0] PH_CFG0     = 4'd4;
    localparam logic [3:0] PH_CFG1     = 4'd5;
    localparam logic [3:0] PH_CFG2     = 4'd6;
    localparam logic [3:0] PH_CFG3     = 4'd7;
    localparam logic [3:0] PH_CFG4     = 4'd8;
    localparam logic [3:0] PH_CFGONLY0 = 4'd9;
    localparam logic [3:0] PH_CFGONLY1 = 4'd10;
    localparam logic [3:0] PH_STR0     = 4'd11;
    localparam logic [3:0] PH_STR1     = 4'd12;
    localparam logic [3:0] PH_STR2     = 4'd13;

    // Standard request codes and descriptor types.
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;
    localparam logic [7:0] STR_LANGUAGE = 8'd0;
    localparam logic [7:0] STR_MAKER    = 8'd1;
    localparam logic [7:0] STR_PRODUCT  = 8'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_VENDOR_ID        = 3'd0;
    localparam logic [2:0] CFG_PRODUCT_ID       = 3'd1;
    localparam logic [2:0] CFG_DEVICE_RELEASE   = 3'd2;
    localparam logic [2:0] CFG_MAX_POWER_UNITS  = 3'd3;
    localparam logic [2:0] CFG_BULK_PACKET_SIZE = 3'd4;

    localparam logic [7:0]  ADDRESS_ENABLE    = 8'h80;
    localparam logic [15:0] CONFIG_HEADER_LEN = 16'd9;
    localparam logic [5:0]  MAKER_LEN         = 6'd22;
    localparam logic [5:0]  PRODUCT_LEN       = 6'd44;

    typedef struct packed {
        logic        setup_end_flag;
        logic        sent_stall_flag;
        logic        out_ready_flag;
        logic [7:0]  request_code;
        logic [7:0]  value_low;
        logic [7:0]  value_high;
        logic [15:0] requested_length;
    } t_item;

    typedef struct packed {
        logic [63:0] packet_bytes;
        logic [3:0]  packet_length;
        logic        in_ready_set;
        logic        data_end_set;
        logic        out_ready_clear;
        logic        setup_end_clear;
        logic        stall_clear;
        logic        address_write;
        logic [7:0]  function_address;
        logic        configured;
        logic [7:0]  configuration_value;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [15:0] device_release;
        logic [7:0]  max_power_units;
        logic [6:0]  bulk_packet_size;
    } t_cfg_regs;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] chunk;
        logic       configured;
        logic [7:0] config_value;
    } t_state;

    // Manufacturer string descriptor, UTF-16LE; zero past its end.
    function automatic logic [7:0] maker_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h16;
            6'd1:    b = 8'h03;
            6'd2:    b = 8'h53;
            6'd4:    b = 8'h79;
            6'd6:    b = 8'h73;
            6'd8:    b = 8'h74;
            6'd10:   b = 8'h65;
            6'd12:   b = 8'h6D;
            6'd14:   b = 8'h20;
            6'd16:   b = 8'h4D;
            6'd18:   b = 8'h43;
            6'd20:   b = 8'h55;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Product string descriptor, UTF-16LE; zero past its end.
    function automatic logic [7:0] product_byte(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h2C;
            6'd1:    b = 8'h03;
            6'd2:    b = 8'h53;
            6'd4:    b = 8'h45;
            6'd6:    b = 8'h43;
            6'd8:    b = 8'h20;
            6'd10:   b = 8'h53;
            6'd12:   b = 8'h33;
            6'd14:   b = 8'h43;
            6'd16:   b = 8'h32;
            6'd18:   b = 8'h34;
            6'd20:   b = 8'h31;
            6'd22:   b = 8'h30;
            6'd24:   b = 8'h58;
            6'd26:   b = 8'h20;
            6'd28:   b = 8'h54;
            6'd30:   b = 8'h65;
            6'd32:   b = 8'h73;
            6'd34:   b = 8'h74;
            6'd36:   b = 8'h20;
            6'd38:   b = 8'h42;
            6'd40:   b = 8'h2F;
            6'd42:   b = 8'h44;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/ucer_stream_if.sv
// Valid/ready channel used for events, results and register writes.
// The payload type is set per instance, normally a struct from ucer_pkg.
interface ucer_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ucer_decode.sv
// Combinational decode of one endpoint-0 event into the next control state and one result.
// Depends on ucer_pkg for the item, result, state and register types and the string tables.
module ucer_decode (
    input  ucer_pkg::t_state    i_state,
    input  ucer_pkg::t_cfg_regs i_cfg,
    input  ucer_pkg::t_item     i_item,
    output ucer_pkg::t_state    o_state,
    output ucer_pkg::t_result   o_result
);
    import ucer_pkg::*;

    logic [3:0] ph;
    logic [7:0] pkt [PACKET_BYTES];
    logic [5:0] str_off;
    logic [5:0] str_len;
    logic [5:0] str_rem;
    logic       str_full;
    logic [7:0] bps;

    assign bps      = {1'b0, i_cfg.bulk_packet_size};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        ph       = PH_IDLE;
        str_off  = 6'd0;
        str_len  = 6'd0;
        str_rem  = 6'd0;
        str_full = 1'b0;
        for (int k = 0; k < PACKET_BYTES; k++) begin
            pkt[k] = 8'h00;
        end

        if (i_item.setup_end_flag) begin
            o_result.setup_end_clear = 1'b1;
            o_result.out_ready_clear = i_item.out_ready_flag;
            o_state.phase            = PH_IDLE;
        end else if (i_item.sent_stall_flag) begin
            o_result.stall_clear     = 1'b1;
            o_result.out_ready_clear = i_item.out_ready_flag;
            o_state.phase            = PH_IDLE;
        end else begin
            ph = (i_state.phase > PH_STR2) ? PH_IDLE : i_state.phase;

            if (i_item.out_ready_flag && ph == PH_IDLE) begin
                unique case (i_item.request_code)
                    REQ_GET_DESCRIPTOR: begin
                        unique case (i_item.value_high)
                            DESC_DEVICE: begin
                                o_result.out_ready_clear = 1'b1;
                                ph = PH_DEV0;
                            end
                            DESC_CONFIG: begin
                                o_result.out_ready_clear = 1'b1;
                                ph = (i_item.requested_length > CONFIG_HEADER_LEN) ?
                                     PH_CFG0 : PH_CFGONLY0;
                            end
                            DESC_STRING: begin
                                o_result.out_ready_clear = 1'b1;
                                o_state.chunk = 3'd0;
                                unique case (i_item.value_low)
                                    STR_LANGUAGE: ph = PH_STR0;
                                    STR_MAKER:    ph = PH_STR1;
                                    STR_PRODUCT:  ph = PH_STR2;
                                    default:      ph = PH_IDLE;
                                endcase
                            end
                            default: ph = PH_IDLE;
                        endcase
                    end
                    REQ_SET_ADDRESS: begin
                        o_result.address_write    = 1'b1;
                        o_result.function_address = i_item.value_low | ADDRESS_ENABLE;
                        o_result.out_ready_clear  = 1'b1;
                        o_result.data_end_set     = 1'b1;
                    end
                    REQ_SET_CONFIGURATION: begin
                        o_state.config_value     = i_item.value_low;
                        o_state.configured       = 1'b1;
                        o_result.out_ready_clear = 1'b1;
                        o_result.data_end_set    = 1'b1;
                    end
                    default: ph = PH_IDLE;
                endcase
            end

            // A fresh string request restarts at chunk zero, so the offset
            // follows the chunk as updated above.
            str_off  = {o_state.chunk, 3'b000};
            str_len  = (ph == PH_STR2) ? PRODUCT_LEN : MAKER_LEN;
            str_full = ({1'b0, str_off} + 7'd8) < {1'b0, str_len};
            str_rem  = (str_off < str_len) ? (str_len - str_off) : 6'd0;

            o_state.phase = ph;
            unique case (ph)
                PH_DEV0: begin
                    pkt = '{8'h12, 8'h01, 8'h10, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h08};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = PH_DEV1;
                end
                PH_DEV1: begin
                    pkt = '{i_cfg.vendor_id[7:0], i_cfg.vendor_id[15:8],
                            i_cfg.product_id[7:0], i_cfg.product_id[15:8],
                            i_cfg.device_release[7:0], i_cfg.device_release[15:8],
                            8'h01, 8'h02};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = PH_DEV2;
                end
                PH_DEV2: begin
                    pkt[0] = 8'h00;
                    pkt[1] = 8'h01;
                    o_result.packet_length = 4'd2;
                    o_result.in_ready_set  = 1'b1;
                    o_result.data_end_set  = 1'b1;
                    o_state.phase          = PH_IDLE;
                end
                PH_CFG0, PH_CFGONLY0: begin
                    pkt = '{8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = (ph == PH_CFG0) ? PH_CFG1 : PH_CFGONLY1;
                end
                PH_CFG1: begin
                    pkt = '{i_cfg.max_power_units, 8'h09, 8'h04, 8'h00,
                            8'h00, 8'h02, 8'hFF, 8'h00};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = PH_CFG2;
                end
                PH_CFG2: begin
                    pkt = '{8'h00, 8'h00, 8'h07, 8'h05, 8'h81, 8'h02, bps, 8'h00};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = PH_CFG3;
                end
                PH_CFG3: begin
                    // Byte 0 is the first bulk endpoint's polling interval.
                    pkt = '{8'h00, 8'h07, 8'h05, 8'h03, 8'h02, bps, 8'h00, 8'h00};
                    o_result.packet_length = 4'd8;
                    o_result.in_ready_set  = 1'b1;
                    o_state.phase          = PH_CFG4;
                end
                PH_CFG4: begin
                    // Zero-length packet closes the 32-byte reply.
                    o_result.in_ready_set = 1'b1;
                    o_result.data_end_set = 1'b1;
                    o_state.phase         = PH_IDLE;
                end
                PH_CFGONLY1: begin
                    pkt[0] = i_cfg.max_power_units;
                    o_result.packet_length = 4'd1;
                    o_result.in_ready_set  = 1'b1;
                    o_result.data_end_set  = 1'b1;
                    o_state.phase          = PH_IDLE;
                end
                PH_STR0: begin
                    pkt[0] = 8'h04;
                    pkt[1] = 8'h03;
                    pkt[2] = 8'h09;
                    pkt[3] = 8'h04;
                    o_result.packet_length = 4'd4;
                    o_result.in_ready_set  = 1'b1;
                    o_result.data_end_set  = 1'b1;
                    o_state.chunk          = 3'd0;
                    o_state.phase          = PH_IDLE;
                end
                PH_STR1, PH_STR2: begin
                    // The tables read as zero past their end, so a short last
                    // chunk is already padded.
                    for (int k = 0; k < PACKET_BYTES; k++) begin
                        pkt[k] = (ph == PH_STR2) ? product_byte(str_off + 6'(k))
                                                 : maker_byte(str_off + 6'(k));
                    end
                    o_result.in_ready_set = 1'b1;
                    if (str_full) begin
                        o_result.packet_length = 4'd8;
                        o_state.chunk          = o_state.chunk + 3'd1;
                    end else begin
                        o_result.packet_length = str_rem[3:0];
                        o_result.data_end_set  = 1'b1;
                        o_state.chunk          = 3'd0;
                        o_state.phase          = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        for (int k = 0; k < PACKET_BYTES; k++) begin
            o_result.packet_bytes[8*k +: 8] = pkt[k];
        end
        o_result.configured          = o_state.configured;
        o_result.configuration_value = o_state.config_value;
    end

endmodule

FILE: rtl/core/usb_control_endpoint_responder.sv
// Top level of the USB endpoint-0 standard request responder.
// Depends on ucer_pkg, ucer_stream_if and ucer_decode.

// Each word on i_item is one endpoint-0 event (status bits plus the decoded
// setup fields) and yields exactly one word on o_result: up to eight bytes
// for the IN FIFO, first byte in bits 7:0 and unused bytes zero, together
// with the control-register strobes and the current configuration. The block
// takes one event per clock cycle while results are taken; an event is
// registered, decoded against the control state in a single pass, and the
// result plus the updated state are captured together in the output register.
// The only thing that holds events back is a result that has not been taken,
// and even then one more event is absorbed by the input register. Multi-packet
// replies (device, configuration and string descriptors) advance by one packet
// per event, so the firmware sends one event per IN transaction. Descriptor
// fields come from five registers written on i_cfg, which is always ready;
// write them only while no event is in flight.
module usb_control_endpoint_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ucer_stream_if.sink         i_item,
    ucer_stream_if.sink         i_cfg,
    ucer_stream_if.source       o_result
);
    import ucer_pkg::*;

    logic      r_in_valid;
    t_item     r_in;
    logic      r_out_valid;
    t_result   r_out;
    t_state    r_state;
    t_cfg_regs r_cfg;

    t_state    n_state;
    t_result   n_result;
    logic      advance;

    ucer_decode u_decode (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The held event moves on whenever the result register is free or being emptied.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_IDLE, chunk: 3'd0, configured: 1'b0,
                             config_value: 8'd0};
            r_cfg       <= '{vendor_id: 16'd21317, product_id: 16'd4660,
                             device_release: 16'd256, max_power_units: 8'd25,
                             bulk_packet_size: 7'd64};
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    CFG_VENDOR_ID:        r_cfg.vendor_id       <= i_cfg.payload.data;
                    CFG_PRODUCT_ID:       r_cfg.product_id      <= i_cfg.payload.data;
                    CFG_DEVICE_RELEASE:   r_cfg.device_release  <= i_cfg.payload.data;
                    CFG_MAX_POWER_UNITS:  r_cfg.max_power_units <= i_cfg.payload.data[7:0];
                    CFG_BULK_PACKET_SIZE: r_cfg.bulk_packet_size <= i_cfg.payload.data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

endmodule

FILE: rtl/core/ucer_checker.sv
// Port-level assertions for usb_control_endpoint_responder, attached by bind.
// Depends on ucer_pkg for the result type.
module ucer_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_result_valid,
    input logic              i_result_ready,
    input ucer_pkg::t_result i_result
);
    import ucer_pkg::*;

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> i_result.packet_length <= 4'(PACKET_BYTES))
        else $error("packet length above the packet size");

    a_zero_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && i_result.packet_length < 4'(PACKET_BYTES) |->
        (i_result.packet_bytes >> {i_result.packet_length[2:0], 3'b000}) == 64'd0)
        else $error("bytes past the packet length are not zero");

    a_abort_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && (i_result.setup_end_clear || i_result.stall_clear) |->
        !i_result.in_ready_set && !i_result.address_write &&
        i_result.packet_length == 4'd0)
        else $error("an aborting event produced a packet or an address write");

    a_address_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && i_result.address_write |->
        i_result.function_address[7] && i_result.data_end_set && !i_result.in_ready_set)
        else $error("address write without enable bit or status stage");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid && !i_result_ready |=> i_result_valid && $stable(i_result))
        else $error("stalled result word changed or was dropped");

endmodule

bind usb_control_endpoint_responder ucer_checker u_ucer_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_result_valid (o_result.valid),
    .i_result_ready (o_result.ready),
    .i_result       (o_result.payload)
);

FILE: tb/tb_usb_control_endpoint_responder.sv
// Self-checking testbench for the USB endpoint-0 request responder.
// Depends on ucer_pkg, ucer_stream_if and the usb_control_endpoint_responder RTL.
`timescale 1ns / 1ps

module tb_usb_control_endpoint_responder;
    import ucer_pkg::*;

    // A result word passes the input and output registers after its event is taken, so a short
    // settle time after the last result covers anything still in flight.
    localparam int SETTLE_CYCLES  = 8;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASE_EVENTS   = 280;
    localparam int REPORT_LIMIT   = 10;

    // Language ID descriptor (US English) as it leaves the FIFO.
    localparam logic [31:0] LANGUAGE_WORD = 32'h0409_0304;

    // Characters of the manufacturer and product strings, first character in
    // the top byte. The descriptors carry them as UTF-16LE after a two-byte head.
    localparam int          MAKER_CHARS   = 10;
    localparam int          PRODUCT_CHARS = 21;
    localparam logic [8*MAKER_CHARS-1:0]   MAKER_TEXT =
        80'h5379_7374_656D_204D_4355;
    localparam logic [8*PRODUCT_CHARS-1:0] PRODUCT_TEXT =
        168'h5345_4320_5333_4332_3431_3058_2054_6573_7420_422F_44;

    typedef struct {
        t_item   ev;
        bit      typed;
        t_result want;
    } t_directed_row;

    logic clk;
    logic rst_n;

    ucer_stream_if #(.t_payload(t_item))      item_if ();
    ucer_stream_if #(.t_payload(t_cfg_write)) cfg_if ();
    ucer_stream_if #(.t_payload(t_result))    result_if ();

    usb_control_endpoint_responder u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if.sink),
        .i_cfg    (cfg_if.sink),
        .o_result (result_if.source)
    );

    // Shadow copy of the responder: its registers and its control state.
    t_cfg_regs shadow_regs;
    t_state    shadow_state;

    // Results still owed by the block, oldest first.
    t_result   pending_results[$];
    t_directed_row directed_rows[$];

    // Directed rows with a hand-written answer travel alongside the event word,
    // so the scoreboard knows which answer to queue when the word is taken.
    logic      want_typed;
    t_result   want_word;

    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        events_sent    = 0;
    int        sender_idle_pct = 0;
    int        result_stall_pct = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Descriptor contents as the host should see them.
    // ------------------------------------------------------------------
    function automatic logic [7:0] device_desc_byte(input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = 8'h12;
            1:       b = 8'h01;
            2:       b = 8'h10;
            3:       b = 8'h01;
            4:       b = 8'hFF;
            7:       b = 8'h08;
            8:       b = shadow_regs.vendor_id[7:0];
            9:       b = shadow_regs.vendor_id[15:8];
            10:      b = shadow_regs.product_id[7:0];
            11:      b = shadow_regs.product_id[15:8];
            12:      b = shadow_regs.device_release[7:0];
            13:      b = shadow_regs.device_release[15:8];
            14:      b = 8'h01;
            15:      b = 8'h02;
            17:      b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Configuration, interface and the two bulk endpoints. Byte 24 is the
    // first endpoint's bInterval and stays zero.
    function automatic logic [7:0] config_desc_byte(input int idx);
        logic [7:0] b;
        case (idx)
            0, 9:    b = 8'h09;
            1:       b = 8'h02;
            2:       b = 8'h20;
            4, 5:    b = 8'h01;
            7:       b = 8'hC0;
            8:       b = shadow_regs.max_power_units;
            10:      b = 8'h04;
            13:      b = 8'h02;
            14:      b = 8'hFF;
            18, 25:  b = 8'h07;
            19, 26:  b = 8'h05;
            20:      b = 8'h81;
            21, 28:  b = 8'h02;
            22, 29:  b = {1'b0, shadow_regs.bulk_packet_size};
            27:      b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] string_desc_byte(input bit product, input int idx);
        int chars;
        int total;
        int k;
        chars = product ? PRODUCT_CHARS : MAKER_CHARS;
        total = 2 + 2 * chars;
        if (idx == 0)
            return 8'(total);
        if (idx == 1)
            return 8'h03;
        if (idx >= total || idx[0])
            return 8'h00;
        k = (idx - 2) / 2;
        return product ? PRODUCT_TEXT[8*(PRODUCT_CHARS-1-k) +: 8]
                       : MAKER_TEXT[8*(MAKER_CHARS-1-k) +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Predictor: works out the answer to one event and advances the shadow
    // control state the way the block should.
    // ------------------------------------------------------------------
    function automatic t_result predict_response(input t_item ev);
        t_result r;
        int      base;
        int      total;
        int      count;
        int      k;
        bit      product;
        r = '0;
        count = 0;
        if (ev.setup_end_flag) begin
            // Host ended the transfer early; this outranks everything else.
            r.setup_end_clear = 1'b1;
            r.out_ready_clear = ev.out_ready_flag;
            shadow_state.phase = PH_IDLE;
        end else if (ev.sent_stall_flag) begin
            r.stall_clear = 1'b1;
            r.out_ready_clear = ev.out_ready_flag;
            shadow_state.phase = PH_IDLE;
        end else begin
            if (shadow_state.phase > PH_STR2)
                shadow_state.phase = PH_IDLE;
            // A setup packet is only decoded while no reply is running.
            if (ev.out_ready_flag && shadow_state.phase == PH_IDLE) begin
                case (ev.request_code)
                    REQ_GET_DESCRIPTOR: begin
                        case (ev.value_high)
                            DESC_DEVICE: begin
                                r.out_ready_clear = 1'b1;
                                shadow_state.phase = PH_DEV0;
                            end
                            DESC_CONFIG: begin
                                r.out_ready_clear = 1'b1;
                                shadow_state.phase =
                                    (ev.requested_length > CONFIG_HEADER_LEN) ?
                                    PH_CFG0 : PH_CFGONLY0;
                            end
                            DESC_STRING: begin
                                // An unknown index still drops the setup packet.
                                r.out_ready_clear = 1'b1;
                                shadow_state.chunk = '0;
                                case (ev.value_low)
                                    STR_LANGUAGE: shadow_state.phase = PH_STR0;
                                    STR_MAKER:    shadow_state.phase = PH_STR1;
                                    STR_PRODUCT:  shadow_state.phase = PH_STR2;
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                    REQ_SET_ADDRESS: begin
                        r.address_write = 1'b1;
                        r.function_address = ev.value_low | ADDRESS_ENABLE;
                        r.out_ready_clear = 1'b1;
                        r.data_end_set = 1'b1;
                    end
                    REQ_SET_CONFIGURATION: begin
                        shadow_state.config_value = ev.value_low;
                        shadow_state.configured = 1'b1;
                        r.out_ready_clear = 1'b1;
                        r.data_end_set = 1'b1;
                    end
                    default: ;
                endcase
            end

            case (shadow_state.phase)
                PH_DEV0, PH_DEV1, PH_DEV2: begin
                    base = 8 * (int'(shadow_state.phase) - int'(PH_DEV0));
                    count = (shadow_state.phase == PH_DEV2) ? 2 : 8;
                    for (k = 0; k < count; k++)
                        r.packet_bytes[8*k +: 8] = device_desc_byte(base + k);
                    r.in_ready_set = 1'b1;
                    if (shadow_state.phase == PH_DEV2) begin
                        r.data_end_set = 1'b1;
                        shadow_state.phase = PH_IDLE;
                    end else begin
                        shadow_state.phase = shadow_state.phase + 4'd1;
                    end
                end
                PH_CFG0, PH_CFG1, PH_CFG2, PH_CFG3: begin
                    base = 8 * (int'(shadow_state.phase) - int'(PH_CFG0));
                    count = 8;
                    for (k = 0; k < count; k++)
                        r.packet_bytes[8*k +: 8] = config_desc_byte(base + k);
                    r.in_ready_set = 1'b1;
                    shadow_state.phase = shadow_state.phase + 4'd1;
                end
                PH_CFG4: begin
                    // Zero-length packet closes the 32-byte reply.
                    r.in_ready_set = 1'b1;
                    r.data_end_set = 1'b1;
                    shadow_state.phase = PH_IDLE;
                end
                PH_CFGONLY0: begin
                    count = 8;
                    for (k = 0; k < count; k++)
                        r.packet_bytes[8*k +: 8] = config_desc_byte(k);
                    r.in_ready_set = 1'b1;
                    shadow_state.phase = PH_CFGONLY1;
                end
                PH_CFGONLY1: begin
                    count = 1;
                    r.packet_bytes[7:0] = config_desc_byte(8);
                    r.in_ready_set = 1'b1;
                    r.data_end_set = 1'b1;
                    shadow_state.phase = PH_IDLE;
                end
                PH_STR0: begin
                    count = 4;
                    r.packet_bytes[31:0] = LANGUAGE_WORD;
                    r.in_ready_set = 1'b1;
                    r.data_end_set = 1'b1;
                    shadow_state.chunk = '0;
                    shadow_state.phase = PH_IDLE;
                end
                PH_STR1, PH_STR2: begin
                    product = (shadow_state.phase == PH_STR2);
                    total = product ? int'(PRODUCT_LEN) : int'(MAKER_LEN);
                    base = 8 * int'(shadow_state.chunk);
                    if (base + 8 < total) begin
                        count = 8;
                        shadow_state.chunk = shadow_state.chunk + 3'd1;
                    end else begin
                        // Last chunk: whatever is left, possibly nothing.
                        count = (base < total) ? total - base : 0;
                        shadow_state.chunk = '0;
                        r.data_end_set = 1'b1;
                        shadow_state.phase = PH_IDLE;
                    end
                    for (k = 0; k < count; k++)
                        r.packet_bytes[8*k +: 8] = string_desc_byte(product, base + k);
                    r.in_ready_set = 1'b1;
                end
                default: ;
            endcase
        end
        r.packet_length = 4'(count);
        r.configured = shadow_state.configured;
        r.configuration_value = shadow_state.config_value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard.
    // ------------------------------------------------------------------
    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                         want, got);
        end
    endtask

    task automatic compare_result(input t_result want, input t_result got);
        note_field("packet_bytes", want.packet_bytes, got.packet_bytes);
        note_field("packet_length", 64'(want.packet_length), 64'(got.packet_length));
        note_field("in_ready_set", 64'(want.in_ready_set), 64'(got.in_ready_set));
        note_field("data_end_set", 64'(want.data_end_set), 64'(got.data_end_set));
        note_field("out_ready_clear", 64'(want.out_ready_clear),
                   64'(got.out_ready_clear));
        note_field("setup_end_clear", 64'(want.setup_end_clear),
                   64'(got.setup_end_clear));
        note_field("stall_clear", 64'(want.stall_clear), 64'(got.stall_clear));
        note_field("address_write", 64'(want.address_write), 64'(got.address_write));
        note_field("function_address", 64'(want.function_address),
                   64'(got.function_address));
        note_field("configured", 64'(want.configured), 64'(got.configured));
        note_field("configuration_value", 64'(want.configuration_value),
                   64'(got.configuration_value));
    endtask

    // Everything is sampled at the rising edge, before the nonblocking updates
    // of that edge land. A result word is retired before a new event word is
    // queued, since a result taken at an edge always belongs to an older event.
    always @(posedge clk) begin : scoreboard
        t_result predicted;
        if (rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result word with nothing outstanding: %h",
                                 $realtime, result_if.payload);
                end else begin
                    compare_result(pending_results.pop_front(), result_if.payload);
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.payload.index)
                    CFG_VENDOR_ID:        shadow_regs.vendor_id = cfg_if.payload.data;
                    CFG_PRODUCT_ID:       shadow_regs.product_id = cfg_if.payload.data;
                    CFG_DEVICE_RELEASE:   shadow_regs.device_release = cfg_if.payload.data;
                    CFG_MAX_POWER_UNITS:
                        shadow_regs.max_power_units = cfg_if.payload.data[7:0];
                    CFG_BULK_PACKET_SIZE:
                        shadow_regs.bulk_packet_size = cfg_if.payload.data[6:0];
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready) begin
                // The predictor always runs so its state follows every event.
                predicted = predict_response(item_if.payload);
                pending_results.push_back(want_typed ? want_word : predicted);
            end
        end
    end

    // Ends the run if nothing at all moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: takes words or stalls at the rate the current phase asks for.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= result_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_item make_event(input logic se, input logic st, input logic ordy,
                                         input logic [7:0] req, input logic [7:0] vlo,
                                         input logic [7:0] vhi, input logic [15:0] wlen);
        t_item e;
        e.setup_end_flag = se;
        e.sent_stall_flag = st;
        e.out_ready_flag = ordy;
        e.request_code = req;
        e.value_low = vlo;
        e.value_high = vhi;
        e.requested_length = wlen;
        return e;
    endfunction

    function automatic t_result make_result(input logic [63:0] bytes, input logic [3:0] len,
                                            input logic in_rdy, input logic dend,
                                            input logic oclr, input logic seclr,
                                            input logic stclr, input logic awr,
                                            input logic [7:0] faddr, input logic conf,
                                            input logic [7:0] cval);
        t_result r;
        r.packet_bytes = bytes;
        r.packet_length = len;
        r.in_ready_set = in_rdy;
        r.data_end_set = dend;
        r.out_ready_clear = oclr;
        r.setup_end_clear = seclr;
        r.stall_clear = stclr;
        r.address_write = awr;
        r.function_address = faddr;
        r.configured = conf;
        r.configuration_value = cval;
        return r;
    endfunction

    function automatic void add_row(input t_item ev, input bit typed, input t_result want);
        directed_rows.push_back('{ev, typed, want});
    endfunction

    // Any event at all; request and wValue lean toward the codes the block knows.
    function automatic t_item random_event();
        t_item e;
        e.setup_end_flag = ($urandom_range(0, 7) == 0);
        e.sent_stall_flag = ($urandom_range(0, 7) == 0);
        e.out_ready_flag = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0) begin
            e.request_code = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 2))
                0:       e.request_code = REQ_SET_ADDRESS;
                1:       e.request_code = REQ_GET_DESCRIPTOR;
                default: e.request_code = REQ_SET_CONFIGURATION;
            endcase
        end
        e.value_low = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(0, 255));
        e.value_high = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(0, 255));
        e.requested_length = 16'($urandom_range(0, 65535));
        return e;
    endfunction

    // Puts one event word up and holds it until taken. Valid stays high on
    // return, so back-to-back words need no extra edge.
    task automatic send_item(input t_item ev, input bit typed, input t_result want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.payload <= ev;
        want_typed <= typed;
        want_word <= want;
        do
            @(posedge clk);
        while (!item_if.ready);
        events_sent++;
    endtask

    // Stops sending and waits until every owed result word has been taken.
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five descriptor registers in one burst; the block must be idle.
    task automatic write_settings(input logic [15:0] vid, input logic [15:0] pid,
                                  input logic [15:0] rel, input logic [7:0] power,
                                  input logic [6:0] bulk);
        t_cfg_write writes [5];
        writes[0] = '{CFG_VENDOR_ID, vid};
        writes[1] = '{CFG_PRODUCT_ID, pid};
        writes[2] = '{CFG_DEVICE_RELEASE, rel};
        writes[3] = '{CFG_MAX_POWER_UNITS, {8'h00, power}};
        writes[4] = '{CFG_BULK_PACKET_SIZE, {9'h000, bulk}};
        foreach (writes[i]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.payload <= writes[i];
            do
                @(posedge clk);
            while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // One host transfer: a setup event followed by one event per IN packet the
    // reply needs. Now and then the transfer is cut short by a setup end or a
    // stall, gets a stray setup while busy, or an extra event after its end.
    task automatic random_transaction();
        t_item s;
        t_item f;
        int    kind;
        int    follow;
        int    k;
        bit    abort;
        s = random_event();
        s.setup_end_flag = 1'b0;
        s.sent_stall_flag = 1'b0;
        s.out_ready_flag = 1'b1;
        follow = 0;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            s.request_code = REQ_GET_DESCRIPTOR;
            s.value_high = DESC_DEVICE;
            follow = 2;
        end else if (kind < 35) begin
            s.request_code = REQ_GET_DESCRIPTOR;
            s.value_high = DESC_CONFIG;
            case ($urandom_range(0, 5))
                0:       s.requested_length = 16'd0;
                1:       s.requested_length = 16'd9;
                2:       s.requested_length = 16'd10;
                3:       s.requested_length = 16'hFFFF;
                4:       s.requested_length = 16'($urandom_range(0, 9));
                default: s.requested_length = 16'($urandom_range(10, 65535));
            endcase
            follow = (s.requested_length > CONFIG_HEADER_LEN) ? 4 : 1;
        end else if (kind < 55) begin
            s.request_code = REQ_GET_DESCRIPTOR;
            s.value_high = DESC_STRING;
            s.value_low = 8'($urandom_range(0, 3));
            if (s.value_low == 8'd3)
                s.value_low = 8'($urandom_range(3, 255));
            if (s.value_low == STR_MAKER)
                follow = 2;
            else if (s.value_low == STR_PRODUCT)
                follow = 5;
        end else if (kind < 65) begin
            s.request_code = REQ_SET_ADDRESS;
        end else if (kind < 73) begin
            s.request_code = REQ_SET_CONFIGURATION;
        end else begin
            s = random_event();
        end
        send_item(s, 1'b0, '0);

        if ($urandom_range(0, 9) == 0)
            follow++;
        for (k = 0; k < follow; k++) begin
            f = random_event();
            abort = 1'b0;
            case ($urandom_range(0, 39))
                0: begin
                    f.setup_end_flag = 1'b1;
                    abort = 1'b1;
                end
                1: begin
                    f.setup_end_flag = 1'b0;
                    f.sent_stall_flag = 1'b1;
                    abort = 1'b1;
                end
                2, 3: begin
                    f.setup_end_flag = 1'b0;
                    f.sent_stall_flag = 1'b0;
                    f.out_ready_flag = 1'b1;
                end
                default: begin
                    f.setup_end_flag = 1'b0;
                    f.sent_stall_flag = 1'b0;
                    f.out_ready_flag = 1'b0;
                end
            endcase
            send_item(f, 1'b0, '0);
            if (abort)
                break;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_item in_event;
        int    phase;
        int    target;

        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        want_typed = 1'b0;
        want_word = '0;

        // Shadow state as it should come out of reset.
        shadow_regs = '{16'd21317, 16'd4660, 16'd256, 8'd25, 7'd64};
        shadow_state = '0;

        // Directed table, run with the reset register values. Answers that
        // can be read straight off the descriptors are written out here; the
        // rest come from the predictor. The block is unconfigured until the
        // set configuration row near the end.
        in_event = make_event(0, 0, 0, 8'h00, 8'h00, 8'h00, 16'h0000);
        add_row(make_event(0, 0, 1, REQ_SET_ADDRESS, 8'h00, 8'h00, 16'h0000), 1,
                make_result(64'h0, 0, 0, 1, 1, 0, 0, 1, 8'h80, 0, 8'h00));
        add_row(make_event(0, 0, 1, REQ_SET_ADDRESS, 8'hFF, 8'hFF, 16'hFFFF), 1,
                make_result(64'h0, 0, 0, 1, 1, 0, 0, 1, 8'hFF, 0, 8'h00));
        // Device descriptor in three packets, vendor/product/release at reset.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, DESC_DEVICE, 16'd18), 1,
                make_result(64'h0800_00FF_0110_0112, 8, 1, 0, 1, 0, 0, 0, 8'h00, 0, 8'h00));
        add_row(in_event, 1,
                make_result(64'h0201_0100_1234_5345, 8, 1, 0, 0, 0, 0, 0, 8'h00, 0, 8'h00));
        add_row(in_event, 1,
                make_result(64'h0000_0000_0000_0100, 2, 1, 1, 0, 0, 0, 0, 8'h00, 0, 8'h00));
        // Full configuration reply: four data packets and a zero-length end.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'hFFFF), 1,
                make_result(64'hC000_0101_0020_0209, 8, 1, 0, 1, 0, 0, 0, 8'h00, 0, 8'h00));
        repeat (4) add_row(in_event, 0, '0);
        // A length of exactly nine gets the header alone.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'd9), 0, '0);
        add_row(in_event, 0, '0);
        // One byte more picks the full reply, which a setup end then cuts short.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, DESC_CONFIG, 16'd10), 0, '0);
        add_row(make_event(1, 0, 1, 8'h00, 8'h00, 8'h00, 16'h0000), 1,
                make_result(64'h0, 0, 0, 0, 1, 1, 0, 0, 8'h00, 0, 8'h00));
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, STR_LANGUAGE, DESC_STRING, 16'd255),
                1, make_result(64'(LANGUAGE_WORD), 4, 1, 1, 1, 0, 0, 0, 8'h00, 0, 8'h00));
        // Manufacturer string in 8-byte chunks, the last one short.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, STR_MAKER, DESC_STRING, 16'd255),
                0, '0);
        repeat (2) add_row(in_event, 0, '0);
        // Product string, aborted by a stall after the first chunk.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, STR_PRODUCT, DESC_STRING, 16'd255),
                0, '0);
        add_row(make_event(0, 1, 0, 8'h00, 8'h00, 8'h00, 16'h0000), 1,
                make_result(64'h0, 0, 0, 0, 0, 0, 1, 0, 8'h00, 0, 8'h00));
        // Unknown string index: setup packet dropped, nothing sent.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'hFF, DESC_STRING, 16'd255), 1,
                make_result(64'h0, 0, 0, 0, 1, 0, 0, 0, 8'h00, 0, 8'h00));
        // Unknown descriptor type and unknown request: left alone entirely.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, 8'h00, 16'd255), 1,
                make_result(64'h0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0, 8'h00));
        add_row(make_event(0, 0, 1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1,
                make_result(64'h0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0, 8'h00));
        // A setup arriving mid-reply is ignored and the reply carries on.
        add_row(make_event(0, 0, 1, REQ_GET_DESCRIPTOR, 8'h00, DESC_DEVICE, 16'd64), 0, '0);
        add_row(make_event(0, 0, 1, REQ_SET_ADDRESS, 8'h2A, 8'h00, 16'h0000), 0, '0);
        add_row(in_event, 0, '0);
        add_row(make_event(0, 0, 1, REQ_SET_CONFIGURATION, 8'hFF, 8'h00, 16'h0000), 1,
                make_result(64'h0, 0, 0, 1, 1, 0, 0, 0, 8'h00, 1, 8'hFF));
        // Setup end and stall together: setup end wins.
        add_row(make_event(1, 1, 0, 8'h00, 8'h00, 8'h00, 16'h0000), 1,
                make_result(64'h0, 0, 0, 0, 0, 1, 0, 0, 8'h00, 1, 8'hFF));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // Random transfers in four phases, each with its own register setting
        // and its own idling pattern: none, sender gaps, result stalls, both.
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_settings(16'h0000, 16'h0000, 16'h0000, 8'h00, 7'd8);
                    sender_idle_pct = 0;
                    result_stall_pct = 0;
                end
                1: begin
                    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 7'd64);
                    sender_idle_pct = 55;
                    result_stall_pct = 0;
                end
                2: begin
                    write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                                   7'($urandom_range(8, 64)));
                    sender_idle_pct = 0;
                    result_stall_pct = 55;
                end
                default: begin
                    write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                                   7'($urandom_range(8, 64)));
                    sender_idle_pct = 8;
                    result_stall_pct = 8;
                end
            endcase
            target = events_sent + PHASE_EVENTS;
            while (events_sent < target)
                random_transaction();
        end

        wait_drained();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
